/* hw/rtl/mcsw_pkg.sv */
// Shared types and constants of the multi-channel watchdog.
// Holds the command codes, the microcode word layout and the microcode table.
// No dependencies.
package mcsw_pkg;

  // Command codes carried by an input item.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_FEED  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  // Field widths fixed by the item format.
  localparam int unsigned CH_FIELD_W  = 4;
  localparam int unsigned TMO_W       = 24;
  localparam int unsigned EXP_CH_W    = 3;
  localparam logic [TMO_W-1:0] RESET_TIMEOUT = 24'd300;

  // Microcode addresses.
  typedef enum logic [1:0] {
    UA_FETCH = 2'd0,
    UA_SCAN  = 2'd1,
    UA_APPLY = 2'd2,
    UA_EMIT  = 2'd3
  } uaddr_t;

  // Sequencing conditions of a microcode word.
  typedef enum logic [1:0] {
    COND_GOTO     = 2'd0,
    COND_DISPATCH = 2'd1,
    COND_SCAN     = 2'd2
  } cond_t;

  // One control word.
  typedef struct packed {
    logic   idle;
    logic   scan;
    logic   apply;
    logic   emit;
    cond_t  cond;
    uaddr_t target;
    uaddr_t alt;
  } ucode_t;

  // Controls from the sequencer to the channel file.
  typedef struct packed {
    logic clear;
    logic scan;
    logic apply;
  } dp_ctrl_t;

  // Result of one item.
  typedef struct packed {
    logic                expired;
    logic [EXP_CH_W-1:0] expired_channel;
    logic                report_needed;
    logic                bad_channel;
  } result_t;

  // Microcode table: fetch and dispatch, channel scan, single-channel update, result.
  function automatic ucode_t ucode_rom(input uaddr_t addr);
    ucode_t w;
    case (addr)
      UA_FETCH: w = '{idle: 1'b1, scan: 1'b0, apply: 1'b0, emit: 1'b0,
                      cond: COND_DISPATCH, target: UA_SCAN, alt: UA_APPLY};
      UA_SCAN:  w = '{idle: 1'b0, scan: 1'b1, apply: 1'b0, emit: 1'b0,
                      cond: COND_SCAN, target: UA_EMIT, alt: UA_SCAN};
      UA_APPLY: w = '{idle: 1'b0, scan: 1'b0, apply: 1'b1, emit: 1'b0,
                      cond: COND_GOTO, target: UA_EMIT, alt: UA_EMIT};
      UA_EMIT:  w = '{idle: 1'b0, scan: 1'b0, apply: 1'b0, emit: 1'b1,
                      cond: COND_GOTO, target: UA_FETCH, alt: UA_FETCH};
      default:  w = '{idle: 1'b1, scan: 1'b0, apply: 1'b0, emit: 1'b0,
                      cond: COND_GOTO, target: UA_FETCH, alt: UA_FETCH};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/mcsw_chan_file.sv */
// Channel file of the watchdog: counters, enables and timeouts, one channel per cycle.
// Driven by the sequencer in the top level; depends on mcsw_pkg.
module mcsw_chan_file #(
  parameter int unsigned CHANNELS        = 8,
  parameter int unsigned NETWORK_CHANNEL = 0,
  parameter int unsigned COUNT_WIDTH     = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mcsw_pkg::dp_ctrl_t                    ctrl,
  input  mcsw_pkg::cmd_t                        cmd,
  input  logic [mcsw_pkg::CH_FIELD_W-1:0]       ch,
  input  logic [mcsw_pkg::TMO_W-1:0]            tmo,
  output logic                                  last,
  output mcsw_pkg::result_t                     res
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CMP_W = (COUNT_WIDTH > mcsw_pkg::TMO_W) ? COUNT_WIDTH
                                                                  : mcsw_pkg::TMO_W;
  localparam int unsigned CHN_W = mcsw_pkg::CH_FIELD_W + 1;

  logic [COUNT_WIDTH-1:0]    count_r [CHANNELS];
  logic [mcsw_pkg::TMO_W-1:0] tmo_r  [CHANNELS];
  logic [CHANNELS-1:0]       en_r;

  logic [IDX_W-1:0]          idx_r;
  logic                      found_r;
  logic [IDX_W-1:0]          found_idx_r;
  logic                      report_r;
  logic                      bad_r;

  logic                      bad;
  logic [IDX_W-1:0]          addr;
  logic [COUNT_WIDTH-1:0]    cnt_rd;
  logic [COUNT_WIDTH-1:0]    cnt_inc;
  logic [mcsw_pkg::TMO_W-1:0] tmo_rd;
  logic                      hit;

  // Address decode: the scan index while scanning, else the command's channel.
  assign bad    = CHN_W'(ch) >= CHN_W'(CHANNELS);
  assign addr   = ctrl.scan ? idx_r : ch[IDX_W-1:0];
  assign last   = idx_r == IDX_W'(CHANNELS - 1);

  // Saturating increment and expiry check of the scanned channel.
  assign cnt_rd  = count_r[addr];
  assign tmo_rd  = tmo_r[addr];
  assign cnt_inc = (cnt_rd == {COUNT_WIDTH{1'b1}}) ? cnt_rd : cnt_rd + COUNT_WIDTH'(1);
  assign hit     = en_r[addr] && (CMP_W'(cnt_inc) >= CMP_W'(tmo_rd));

  // Channel state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CHANNELS; k++) begin
        count_r[k] <= '0;
        en_r[k]    <= (k == NETWORK_CHANNEL);
        tmo_r[k]   <= (k == NETWORK_CHANNEL) ? mcsw_pkg::RESET_TIMEOUT : '0;
      end
    end else if (ctrl.scan) begin
      count_r[addr] <= cnt_inc;
    end else if (ctrl.apply && !bad) begin
      case (cmd)
        mcsw_pkg::CMD_FEED: begin
          count_r[addr] <= '0;
        end
        mcsw_pkg::CMD_START: begin
          count_r[addr] <= '0;
          en_r[addr]    <= 1'b1;
          tmo_r[addr]   <= tmo;
        end
        mcsw_pkg::CMD_STOP: begin
          en_r[addr] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Scan index and result registers; the first hit of a scan is kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      found_r     <= 1'b0;
      found_idx_r <= '0;
      report_r    <= 1'b0;
      bad_r       <= 1'b0;
    end else if (ctrl.clear) begin
      idx_r       <= '0;
      found_r     <= 1'b0;
      found_idx_r <= '0;
      report_r    <= 1'b0;
      bad_r       <= 1'b0;
    end else if (ctrl.scan) begin
      if (!last) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (hit && !found_r) begin
        found_r     <= 1'b1;
        found_idx_r <= idx_r;
        report_r    <= CHN_W'(idx_r) != CHN_W'(NETWORK_CHANNEL);
      end
    end else if (ctrl.apply) begin
      bad_r <= bad;
    end
  end

  assign res.expired         = found_r;
  assign res.expired_channel = mcsw_pkg::EXP_CH_W'(found_idx_r);
  assign res.report_needed   = report_r;
  assign res.bad_channel     = bad_r;

endmodule

/* hw/rtl/multi_channel_soft_watchdog.sv */
// Top level of the multi-channel watchdog: microcoded sequencer and command latch.
// Depends on mcsw_pkg and mcsw_chan_file.
//
// Usage: an item (command) is taken when start is high and busy is low. A tick
// item walks the channels one per cycle through the single channel-file port in
// the scan state; its result then strobes on out_valid in the emit state, and the
// block returns to fetch to take the next item. Feed, start and stop go from fetch
// through the apply state to the emit state. No new item is taken until the
// result is out. Each result is shown for exactly one cycle and must be captured
// then; the block never waits for the receiver.
module multi_channel_soft_watchdog #(
  parameter int unsigned CHANNELS        = 8,
  parameter int unsigned NETWORK_CHANNEL = 0,
  parameter int unsigned COUNT_WIDTH     = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [3:0]  in_channel,
  input  logic [23:0] in_timeout,
  output logic        out_valid,
  output logic        out_expired,
  output logic [2:0]  out_expired_channel,
  output logic        out_report_needed,
  output logic        out_bad_channel
);

  mcsw_pkg::uaddr_t   upc_r;
  mcsw_pkg::uaddr_t   upc_nxt;
  mcsw_pkg::ucode_t   uw;
  mcsw_pkg::cmd_t     cmd_r;
  logic [3:0]         ch_r;
  logic [23:0]        tmo_r;
  mcsw_pkg::dp_ctrl_t ctrl;
  mcsw_pkg::result_t  res;
  logic               last;
  logic               accept;

  assign uw     = mcsw_pkg::ucode_rom(upc_r);
  assign accept = start && uw.idle;

  // Next microcode address.
  always_comb begin
    upc_nxt = upc_r;
    case (uw.cond)
      mcsw_pkg::COND_GOTO: begin
        upc_nxt = uw.target;
      end
      mcsw_pkg::COND_DISPATCH: begin
        if (start) begin
          upc_nxt = (mcsw_pkg::cmd_t'(in_cmd) == mcsw_pkg::CMD_TICK) ? uw.target : uw.alt;
        end
      end
      mcsw_pkg::COND_SCAN: begin
        upc_nxt = last ? uw.target : uw.alt;
      end
      default: begin
        upc_nxt = mcsw_pkg::UA_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= mcsw_pkg::UA_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // Command latch on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= mcsw_pkg::cmd_t'(in_cmd);
      ch_r  <= in_channel;
      tmo_r <= in_timeout;
    end
  end

  // Control outputs decoded from the current word.
  always_comb begin
    busy       = !uw.idle;
    out_valid  = uw.emit;
    ctrl.clear = accept;
    ctrl.scan  = uw.scan;
    ctrl.apply = uw.apply;
  end

  mcsw_chan_file #(
    .CHANNELS        (CHANNELS),
    .NETWORK_CHANNEL (NETWORK_CHANNEL),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_chan_file (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .cmd   (cmd_r),
    .ch    (ch_r),
    .tmo   (tmo_r),
    .last  (last),
    .res   (res)
  );

  assign out_expired         = res.expired;
  assign out_expired_channel = res.expired_channel;
  assign out_report_needed   = res.report_needed;
  assign out_bad_channel     = res.bad_channel;

endmodule

/* hw/rtl/mcsw_checker.sv */
// Port-level checks of the multi-channel watchdog, bound to the top level.
// Depends only on the top level's ports.
module mcsw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_expired,
  input logic [2:0] out_expired_channel,
  input logic       out_report_needed,
  input logic       out_bad_channel
);

  // An accepted item makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after an item was accepted");

  // A result strobe lasts one cycle and the block is then free again.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  // A rejected channel never comes with an expiry.
  a_bad_no_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_channel) |-> !out_expired)
    else $error("bad channel reported together with an expiry");

  // Without an expiry the channel and report fields are zero.
  a_no_expiry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_expired) |-> (out_expired_channel == 3'd0 && !out_report_needed))
    else $error("expiry fields set without an expiry");

endmodule

bind multi_channel_soft_watchdog mcsw_checker u_mcsw_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_expired         (out_expired),
  .out_expired_channel (out_expired_channel),
  .out_report_needed   (out_report_needed),
  .out_bad_channel     (out_bad_channel)
);
